// File: hdl/otem_pkg.sv
package otem_pkg;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_SETP  = 2'd3;

    // Field widths fixed by the word formats
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned DELAY_W  = 32;
    localparam int unsigned EXP_W    = 64;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 72;

    // Events per tick
    localparam int unsigned MAX_EVENTS = 32;
    localparam int unsigned EVCNT_W    = 5;

    // Write enables for the two slot memories
    typedef struct packed {
        logic exp;
        logic per;
    } t_wr_en;

endpackage

// File: hdl/otem_slot_mem.sv
module otem_slot_mem
    import otem_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_rd_addr,
    output logic [EXP_W-1:0]             o_rd_exp,
    output logic [DELAY_W-1:0]           o_rd_per,
    input  t_wr_en                       i_we,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_wr_addr,
    input  logic [EXP_W-1:0]             i_wr_exp,
    input  logic [DELAY_W-1:0]           i_wr_per
);

    logic [EXP_W-1:0]   r_exp_mem [NUM_SLOTS];
    logic [DELAY_W-1:0] r_per_mem [NUM_SLOTS];

    // Expiry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we.exp) begin
            r_exp_mem[i_wr_addr] <= i_wr_exp;
        end
        o_rd_exp <= r_exp_mem[i_rd_addr];
    end

    // Period memory: same organization
    always_ff @(posedge i_clk) begin
        if (i_we.per) begin
            r_per_mem[i_wr_addr] <= i_wr_per;
        end
        o_rd_per <= r_per_mem[i_rd_addr];
    end

endmodule

// File: hdl/ordered_timer_expiry_manager_top.sv
// Start, stop and set-period words are taken in the idle state.
// A tick fires E events (at most 32):
// each event needs one full sweep of the slot memories through their single read port.
// Fired words leave through an output register; the next input word is taken once
// the last event of a tick has been handed to that register.
// Synchronous active-low reset clears the tick counter, all armed marks and the control.
module ordered_timer_expiry_manager_top
    import otem_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // slot_id[3:0], delay_ticks[35:4], periodic[36]
    input  logic [1:0]        i_s_tuser,   // cmd[1:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata,   // fired_slot[3:0], fired_expiry[67:4]
    output logic              o_m_tlast    // last_fired
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);
    localparam logic [EVCNT_W-1:0] LAST_EV = EVCNT_W'(MAX_EVENTS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [EXP_W-1:0]    r_tick;
    logic [NUM_SLOTS-1:0] r_active;
    logic [IW-1:0]       r_addr;
    logic                r_issue_last;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_best_found;
    logic [IW-1:0]       r_best_idx;
    logic [EXP_W-1:0]    r_best_exp;
    logic [DELAY_W-1:0]  r_best_per;
    logic [EVCNT_W-1:0]  r_cnt;
    logic                r_pend;
    logic [IW-1:0]       r_pend_idx;
    logic [EXP_W-1:0]    r_pend_exp;
    logic                r_out_vld;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [EXP_W-1:0]    r_out_exp;
    logic                r_out_last;

    logic [EXP_W-1:0]    rd_exp;
    logic [DELAY_W-1:0]  rd_per;
    t_wr_en              we;
    logic [IW-1:0]       wr_addr;
    logic [EXP_W-1:0]    wr_exp;
    logic [DELAY_W-1:0]  wr_per;

    logic [SLOT_W-1:0]   in_slot;
    logic [DELAY_W-1:0]  in_delay;
    logic                in_per;
    logic                in_acc;
    logic                in_range;
    logic [IW-1:0]       in_idx;
    logic                out_free;
    logic                due;
    logic                better;
    logic                dec_go;
    logic                load_out;
    logic                load_last;

    assign in_slot  = i_s_tdata[3:0];
    assign in_delay = i_s_tdata[35:4];
    assign in_per   = i_s_tdata[36];
    assign in_idx   = IW'(in_slot);
    assign in_range = (32'(in_slot) < 32'(NUM_SLOTS));

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0, r_out_exp, r_out_slot};
    assign o_m_tlast  = r_out_last;

    // Sweep compare on the registered read data
    assign due    = r_active[r_cmp_idx] && (rd_exp <= r_tick);
    assign better = !r_best_found || (rd_exp < r_best_exp);

    // A found event moves on once the pending one can leave
    assign dec_go    = (r_state == ST_DECIDE) && r_best_found && (!r_pend || out_free);
    assign load_out  = (dec_go && r_pend) || load_last;
    assign load_last = (r_state == ST_FLUSH) && r_pend && out_free;

    otem_slot_mem #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (r_addr),
        .o_rd_exp  (rd_exp),
        .o_rd_per  (rd_per),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_exp  (wr_exp),
        .i_wr_per  (wr_per)
    );

    // Memory writes: commands in idle, re-arm of a fired periodic slot
    always_comb begin
        we      = '0;
        wr_addr = in_idx;
        wr_exp  = r_tick + EXP_W'(in_delay);
        wr_per  = in_per ? in_delay : '0;
        if (dec_go) begin
            wr_addr = r_best_idx;
            wr_exp  = r_best_exp + EXP_W'(r_best_per);
            we.exp  = (r_best_per != '0);
        end else if (in_acc && in_range) begin
            unique case (i_s_tuser)
                CMD_START: begin
                    we.exp = 1'b1;
                    we.per = 1'b1;
                end
                CMD_SETP: begin
                    wr_per = in_delay;
                    we.per = 1'b1;
                end
                default: begin
                    we = '0;
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_s_tuser == CMD_TICK) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_issue_last) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_best_found) begin
                    n_state = ST_FLUSH;
                end else if (dec_go) begin
                    n_state = (r_cnt == LAST_EV) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (!r_pend || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tick       <= '0;
            r_active     <= '0;
            r_addr       <= '0;
            r_issue_last <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_best_found <= 1'b0;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;

            // Commands and tick start
            if (in_acc) begin
                if (i_s_tuser == CMD_TICK) begin
                    r_tick       <= r_tick + 1'b1;
                    r_cnt        <= '0;
                    r_addr       <= '0;
                    r_issue_last <= 1'b0;
                    r_best_found <= 1'b0;
                end else if (in_range && i_s_tuser == CMD_START) begin
                    r_active[in_idx] <= 1'b1;
                end else if (in_range && i_s_tuser == CMD_STOP) begin
                    r_active[in_idx] <= 1'b0;
                end
            end

            // Address sweep; the issue of the last slot is flagged in the cycle after
            if (r_state == ST_SCAN && !r_issue_last) begin
                r_addr       <= r_addr + 1'b1;
                r_issue_last <= (r_addr == LAST_SLOT);
            end
            r_cmp_vld <= (r_state == ST_SCAN) && !r_issue_last;

            // Running minimum over due slots, lowest index wins ties
            if (r_cmp_vld && due && better) begin
                r_best_found <= 1'b1;
            end

            // Event accepted: stage it, write back a periodic slot or disarm a one-shot, reset the sweep
            if (dec_go) begin
                r_pend       <= 1'b1;
                r_cnt        <= r_cnt + 1'b1;
                r_addr       <= '0;
                r_issue_last <= 1'b0;
                r_best_found <= 1'b0;
                if (r_best_per == '0) r_active[r_best_idx] <= 1'b0;
            end
            if (load_last) r_pend <= 1'b0;

            // Output register
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && due && better) begin
            r_best_idx <= r_cmp_idx;
            r_best_exp <= rd_exp;
            r_best_per <= rd_per;
        end
        r_cmp_idx <= r_addr;
        if (dec_go) begin
            r_pend_idx <= r_best_idx;
            r_pend_exp <= r_best_exp;
        end
        if (load_out) begin
            r_out_slot <= SLOT_W'(r_pend_idx);
            r_out_exp  <= r_pend_exp;
            r_out_last <= load_last;
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("event left pending while idle");

    a_cap_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_go && r_cnt == LAST_EV) |=> (r_state == ST_FLUSH))
        else $error("event cap not honored");

    a_oneshot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec_go && r_best_per == '0) |=> !r_active[$past(r_best_idx)])
        else $error("one-shot slot still armed after firing");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("output register overwritten");
`endif

endmodule

// File: tb/ordered_timer_expiry_manager_top_tb.sv
module ordered_timer_expiry_manager_top_tb;
    import otem_pkg::*;

    localparam int NUM_SLOTS = 16;
    // one sweep of the slot memories, plus margin for an empty tick
    localparam int SWEEP_CYCLES = NUM_SLOTS + 2;
    localparam int SETTLE_CYCLES = 3 * SWEEP_CYCLES + 8;
    localparam int RANDOM_WORDS = 320;
    localparam int N_DIR = 25;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [EXP_W-1:0]  expiry;
        logic              last;
    } t_fire_event;

    // fixed_n < 0: expectation comes from the predictor; else typed below
    typedef struct {
        logic [1:0]         cmd;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] dly;
        logic               per;
        int                 fixed_n;
        logic [SLOT_W-1:0]  f_slot;
        logic [EXP_W-1:0]   f_expiry;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_DW-1:0]  i_s_tdata;   // slot_id[3:0], delay_ticks[35:4], periodic[36]
    logic [1:0]        i_s_tuser;   // cmd[1:0]
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_tdata;   // fired_slot[3:0], fired_expiry[67:4]
    logic              o_m_tlast;   // last_fired

    // timer state mirror
    logic [EXP_W-1:0]   tick_now;
    logic [EXP_W-1:0]   slot_due_at [NUM_SLOTS];
    logic [DELAY_W-1:0] slot_reload [NUM_SLOTS];
    bit                 slot_armed  [NUM_SLOTS];

    t_fire_event pending_fires[$];
    int          mismatch_count = 0;
    bit          quiet_mode = 1'b0;
    int          rx_stall = 0;

    t_dir_row dir_rows[N_DIR] = '{
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, 0,  4'd0, 64'd0},
        '{CMD_STOP,  4'd3,  32'd0,          1'b0, 0,  4'd0, 64'd0},
        '{CMD_START, 4'd0,  32'd0,          1'b1, 0,  4'd0, 64'd0},
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, 1,  4'd0, 64'd1},
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, 0,  4'd0, 64'd0},
        '{CMD_START, 4'd15, 32'hFFFF_FFFF,  1'b1, 0,  4'd0, 64'd0},
        '{CMD_START, 4'd15, 32'd2,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd1,  32'd1,          1'b1, -1, 4'd0, 64'd0},
        '{CMD_SETP,  4'd1,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_SETP,  4'd2,  32'd5,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd2,  32'd1,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd3,  32'd1,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd4,  32'd1,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd5,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_SETP,  4'd5,  32'd1,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd6,  32'd3,          1'b1, -1, 4'd0, 64'd0},
        '{CMD_STOP,  4'd6,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd7,  32'hFFFF_FFFF,  1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd8,  32'hAAAA_AAAA,  1'b1, -1, 4'd0, 64'd0},
        '{CMD_STOP,  4'd7,  32'd0,          1'b0, -1, 4'd0, 64'd0},
        '{CMD_START, 4'd9,  32'h5555_5555,  1'b0, -1, 4'd0, 64'd0},
        '{CMD_TICK,  4'd0,  32'd0,          1'b0, -1, 4'd0, 64'd0}
    };

    ordered_timer_expiry_manager_top #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // small delays keep slots firing; full-width values exercise every bit
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return '0;
        return $urandom_range(1, 6);
    endfunction

    // apply one command to the timer mirror; queue the fired events if asked
    function automatic void run_timer_cmd(input logic [1:0] cmd,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [DELAY_W-1:0] dly,
                                          input logic per,
                                          input bit record);
        int          best;
        int          n;
        int          i;
        t_fire_event ev;
        t_fire_event burst[$];
        if (cmd == CMD_TICK) begin
            tick_now = tick_now + 64'd1;
            n = 0;
            while (n < MAX_EVENTS) begin
                best = -1;
                for (i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_armed[i] && slot_due_at[i] <= tick_now) begin
                        if (best < 0 || slot_due_at[i] < slot_due_at[best]) best = i;
                    end
                end
                if (best < 0) break;
                ev.slot = best[SLOT_W-1:0];
                ev.expiry = slot_due_at[best];
                ev.last = 1'b0;
                burst.push_back(ev);
                n++;
                if (slot_reload[best] != '0)
                    slot_due_at[best] = slot_due_at[best] + {32'd0, slot_reload[best]};
                else
                    slot_armed[best] = 1'b0;
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            if (record) begin
                foreach (burst[k]) pending_fires.push_back(burst[k]);
            end
        end else if (slot < NUM_SLOTS) begin
            case (cmd)
                CMD_START: begin
                    slot_due_at[slot] = tick_now + {32'd0, dly};
                    slot_reload[slot] = per ? dly : '0;
                    slot_armed[slot] = 1'b1;
                end
                CMD_STOP: slot_armed[slot] = 1'b0;
                default: slot_reload[slot] = dly;
            endcase
        end
    endfunction

    // present one word, wait for the handshake, then update the mirror
    task automatic send_cmd_word(input logic [1:0] cmd, input logic [SLOT_W-1:0] slot,
                                 input logic [DELAY_W-1:0] dly, input logic per,
                                 input bit record);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'b000, per, dly, slot};
        i_s_tuser <= cmd;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        run_timer_cmd(cmd, slot, dly, per, record);
    endtask

    // sender holds off until every queued event has come out
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_fires.size() != 0);
    endtask

    // every slot one-shot at now, then period 1: the next tick fires exactly 32 words
    task automatic full_load_tick();
        int s;
        hold_until_drained();
        for (s = 0; s < NUM_SLOTS; s++) begin
            send_cmd_word(CMD_START, s[SLOT_W-1:0], '0, 1'($urandom_range(0, 1)), 1'b1);
            send_cmd_word(CMD_SETP, s[SLOT_W-1:0], 32'd1, 1'($urandom_range(0, 1)), 1'b1);
        end
        send_cmd_word(CMD_TICK, SLOT_W'($urandom), $urandom, 1'($urandom_range(0, 1)), 1'b1);
        hold_until_drained();
        for (s = 0; s < NUM_SLOTS; s++)
            send_cmd_word(CMD_STOP, s[SLOT_W-1:0], $urandom, 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // output side: random back-pressure and event checking
    always @(posedge i_clk) begin
        t_fire_event want;
        if (o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (pending_fires.size() == 0) begin
                $error("unexpected fired word: slot %0d expiry %0d",
                       o_m_tdata[SLOT_W-1:0], o_m_tdata[SLOT_W +: EXP_W]);
                mismatch_count++;
            end else begin
                want = pending_fires.pop_front();
                if (o_m_tdata[SLOT_W-1:0] !== want.slot) begin
                    $error("fired_slot: expected %0d, got %0d",
                           want.slot, o_m_tdata[SLOT_W-1:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[SLOT_W +: EXP_W] !== want.expiry) begin
                    $error("fired_expiry: expected %0d, got %0d",
                           want.expiry, o_m_tdata[SLOT_W +: EXP_W]);
                    mismatch_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_fired: expected %0d, got %0d", want.last, o_m_tlast);
                    mismatch_count++;
                end
            end
        end
        if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    // main sequence
    initial begin
        int               k;
        int               n_sent;
        int               r;
        int               drain_wait;
        logic [1:0]       c;
        tick_now = '0;
        for (k = 0; k < NUM_SLOTS; k++) begin
            slot_due_at[k] = '0;
            slot_reload[k] = '0;
            slot_armed[k] = 1'b0;
        end
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= CMD_TICK;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (k = 0; k < N_DIR; k++) begin
            send_cmd_word(dir_rows[k].cmd, dir_rows[k].slot, dir_rows[k].dly,
                          dir_rows[k].per, dir_rows[k].fixed_n < 0);
            if (dir_rows[k].fixed_n == 1)
                pending_fires.push_back(t_fire_event'{dir_rows[k].f_slot,
                                                      dir_rows[k].f_expiry, 1'b1});
        end
        hold_until_drained();

        // random traffic with two full-load bursts and a stretch without idling
        n_sent = 0;
        while (n_sent < RANDOM_WORDS) begin
            if (n_sent == 90 || n_sent == 230) begin
                full_load_tick();
                n_sent += 3 * NUM_SLOTS + 1;
            end
            quiet_mode = (n_sent >= 150 && n_sent < 200);
            r = $urandom_range(0, 99);
            if (r < 40)      c = CMD_TICK;
            else if (r < 72) c = CMD_START;
            else if (r < 84) c = CMD_STOP;
            else             c = CMD_SETP;
            send_cmd_word(c, SLOT_W'($urandom), pick_delay(), 1'($urandom_range(0, 1)), 1'b1);
            n_sent++;
        end
        quiet_mode = 1'b0;

        // drain and settle
        i_s_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_fires.size() != 0 && drain_wait < 100000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_fires.size() != 0) begin
            $error("%0d fired words never arrived", pending_fires.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
